// File: design/stick_events_to_servo_frame_macros.svh
// assertion macros for the stick event to servo frame block
`ifndef STICK_EVENTS_TO_SERVO_FRAME_MACROS_SVH
`define STICK_EVENTS_TO_SERVO_FRAME_MACROS_SVH

// same-cycle implication
`define SEFS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEFS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sefs_pkg.sv
// types, constants and mix tables for the stick event to servo frame block
package sefs_pkg;

    localparam int SERVO_SLOTS    = 8;
    localparam int BUTTON_SLOTS   = 12;
    localparam int AXIS_SLOTS_DEF = 6;
    localparam int AXIS_FULL      = 32767;
    localparam int ELEVON_CAP     = 180;
    localparam int AX_ROLL        = 0;
    localparam int AX_PITCH       = 1;
    localparam int AX_THROTTLE    = 2;
    localparam int AX_YAW         = 3;
    localparam int AX_PAN         = 4;
    localparam int AX_TILT        = 5;
    localparam logic [3:0] BYTE_PREFIX    = 4'd0;
    localparam logic [3:0] BYTE_SERVO_END = 4'd8;
    localparam logic [3:0] BYTE_BTN_FIRST = 4'd9;
    localparam logic [3:0] BYTE_BTN_END   = 4'd11;
    localparam logic [3:0] BYTE_CHECKSUM  = 4'd12;
    localparam logic [3:0] DIV_EST_STEP   = 4'd1;

    typedef enum logic [1:0] {
        CFG_TOGGLE_MASK,
        CFG_MULTISTATE,
        CFG_DEADZONE,
        CFG_PREFIX
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_BUTTON,
        CMD_AXIS,
        CMD_TICK,
        CMD_NONE
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_LOAD,
        ST_DIV,
        ST_WB,
        ST_FRAME
    } state_t;

    typedef enum logic [3:0] {
        JOB_ROLL_POS,
        JOB_ROLL_HI,
        JOB_ROLL_NEG,
        JOB_ROLL_LO,
        JOB_YAW,
        JOB_PITCH,
        JOB_THROTTLE,
        JOB_PAN,
        JOB_TILT
    } job_t;

    function automatic logic [7:0] job_gain(input job_t job);
        case (job)
            JOB_ROLL_HI, JOB_ROLL_LO: job_gain = 8'd90;
            JOB_THROTTLE:             job_gain = 8'd254;
            default:                  job_gain = 8'd180;
        endcase
    endfunction

    function automatic logic job_offset(input job_t job);
        case (job)
            JOB_ROLL_POS, JOB_ROLL_HI, JOB_THROTTLE: job_offset = 1'b0;
            default:                                 job_offset = 1'b1;
        endcase
    endfunction

    function automatic logic job_wide(input job_t job);
        case (job)
            JOB_YAW, JOB_PITCH, JOB_PAN, JOB_TILT: job_wide = 1'b1;
            default:                               job_wide = 1'b0;
        endcase
    endfunction

    function automatic int job_axis(input job_t job);
        case (job)
            JOB_YAW:      job_axis = AX_YAW;
            JOB_PITCH:    job_axis = AX_PITCH;
            JOB_THROTTLE: job_axis = AX_THROTTLE;
            JOB_PAN:      job_axis = AX_PAN;
            JOB_TILT:     job_axis = AX_TILT;
            default:      job_axis = AX_ROLL;
        endcase
    endfunction

endpackage

// File: design/stick_events_to_servo_frame.sv
// Stick event to servo frame translator, top level.
// A button or axis event runs from accept to next accept through the accept state, the update
// state, then nine mix jobs, each in the steps load, reciprocal estimate, correction and write
// back, on one shared multiply unit. A tick is accepted and then sends
// 13 output beats, one per cycle when the sink is ready. Only one item is in work.
// Reset (aresetn low at a clock edge) clears the stores and loads the register defaults.
`include "stick_events_to_servo_frame_macros.svh"

module stick_events_to_servo_frame #(
    parameter int AXIS_SLOTS = sefs_pkg::AXIS_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[1:0], slot_number[9:2], event_value[25:10]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_byte[7:0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import sefs_pkg::*;

    localparam int AW = $clog2(AXIS_SLOTS);

    logic [11:0] toggle_mask_reg;
    logic [23:0] multi_reg;
    logic [14:0] deadzone_reg;
    logic [7:0]  prefix_reg;

    state_t state_reg, state_next;
    job_t   job_reg, job_next;
    logic [3:0] step_reg, step_next;
    logic [3:0] byte_reg, byte_next;

    cmd_t               cmd_reg;
    logic [7:0]         slot_reg;
    logic signed [15:0] value_reg;

    logic signed [16:0] axis_reg [AXIS_SLOTS];
    logic [1:0]         btn_reg [BUTTON_SLOTS];
    logic signed [16:0] thr_reg;
    logic [7:0]         servo_reg [SERVO_SLOTS];

    logic [24:0] num_reg;
    logic [8:0]  quo_reg;
    logic [8:0]  yaw_q_reg;
    logic [7:0]  csum_reg;

    logic s_beat, m_beat;
    assign s_beat    = s_tvalid && s_tready;
    assign m_beat    = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            toggle_mask_reg <= 12'd2048;
            multi_reg       <= 24'd2;
            deadzone_reg    <= 15'd5000;
            prefix_reg      <= 8'hFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
                CFG_TOGGLE_MASK: toggle_mask_reg <= cfg_data[11:0];
                CFG_MULTISTATE:  multi_reg       <= cfg_data;
                CFG_DEADZONE:    deadzone_reg    <= cfg_data[14:0];
                CFG_PREFIX:      prefix_reg      <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_ROLL_POS;
            step_reg  <= '0;
            byte_reg  <= '0;
        end else begin
            state_reg <= state_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (cmd_t'(s_tdata[1:0]))
                        CMD_BUTTON, CMD_AXIS: state_next = ST_EVENT;
                        CMD_TICK: begin
                            state_next = ST_FRAME;
                            byte_next  = BYTE_PREFIX;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVENT: begin
                state_next = ST_LOAD;
                job_next   = JOB_ROLL_POS;
            end
            ST_LOAD: begin
                state_next = ST_DIV;
                step_next  = DIV_EST_STEP;
            end
            ST_DIV: begin
                if (step_reg == 4'd0) begin
                    state_next = ST_WB;
                end else begin
                    step_next = step_reg - 4'd1;
                end
            end
            ST_WB: begin
                if (job_reg == JOB_TILT) begin
                    state_next = ST_IDLE;
                end else begin
                    job_next   = job_t'(job_reg + 4'd1);
                    state_next = ST_LOAD;
                end
            end
            ST_FRAME: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (byte_reg == BYTE_CHECKSUM) begin
                        state_next = ST_IDLE;
                    end else begin
                        byte_next = byte_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            cmd_reg   <= cmd_t'(s_tdata[1:0]);
            slot_reg  <= s_tdata[9:2];
            value_reg <= s_tdata[25:10];
        end
    end

    // button update
    logic [3:0]  bidx;
    logic        b_ok, b_tog, v_one;
    logic [23:0] cnt_shift;
    logic [11:0] tog_shift;
    logic [1:0]  cnt, lvl, lvl_new;

    always_comb begin
        bidx      = slot_reg[3:0];
        b_ok      = slot_reg < 8'(BUTTON_SLOTS);
        cnt_shift = multi_reg >> {bidx, 1'b0};
        tog_shift = toggle_mask_reg >> bidx;
        cnt       = cnt_shift[1:0];
        b_tog     = tog_shift[0];
        v_one     = value_reg == 16'sd1;
        lvl       = b_ok ? btn_reg[bidx] : 2'd0;
        lvl_new   = lvl;
        if (b_tog) begin
            if (v_one) lvl_new = (lvl == 2'd0) ? 2'd1 : 2'd0;
        end else if (cnt != 2'd0) begin
            if (v_one) lvl_new = (lvl < cnt) ? lvl + 2'd1 : 2'd0;
        end else begin
            lvl_new = value_reg[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BUTTON_SLOTS; i++) btn_reg[i] <= '0;
        end else if (state_reg == ST_EVENT && cmd_reg == CMD_BUTTON && b_ok) begin
            btn_reg[bidx] <= lvl_new;
        end
    end

    // axis update with deadzone and throttle ratchet
    logic signed [16:0] v_ext, mag, ax_x, ax_neg, ax_pos;
    logic               a_ok, a_thr, a_take;
    logic [AW-1:0]      aidx;

    always_comb begin
        v_ext  = 17'(value_reg);
        mag    = (v_ext < 0) ? -v_ext : v_ext;
        ax_x   = (mag > $signed({2'b00, deadzone_reg})) ? v_ext : 17'sd0;
        ax_neg = -ax_x;
        ax_pos = ax_neg + 17'sd32767;
        aidx   = slot_reg[AW-1:0];
        a_ok   = slot_reg < 8'(AXIS_SLOTS);
        a_thr  = slot_reg == 8'(AX_THROTTLE);
        a_take = (ax_neg > 0) ? (ax_neg > thr_reg) : (ax_pos < thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < AXIS_SLOTS; i++) axis_reg[i] <= '0;
            thr_reg <= '0;
        end else if (state_reg == ST_EVENT && cmd_reg == CMD_AXIS && a_ok) begin
            if (a_thr) begin
                if (a_take) begin
                    axis_reg[aidx] <= (ax_neg > 0) ? ax_neg : ax_pos;
                    thr_reg        <= (ax_neg > 0) ? ax_neg : ax_pos;
                end
            end else begin
                axis_reg[aidx] <= ax_x;
            end
        end
    end

    // shared multiply unit, divide by 32767 as reciprocal estimate plus one correction
    logic signed [16:0] sel_axis, roll;
    logic signed [17:0] s_off;
    logic [16:0]        s_pos;
    logic [24:0]        prod, q_sum, q_back, rem;

    always_comb begin
        sel_axis = axis_reg[AW'(job_axis(job_reg))];
        roll     = axis_reg[AW'(AX_ROLL)];
        s_off    = 18'(sel_axis) + (job_offset(job_reg) ? 18'sd32767 : 18'sd0);
        s_pos    = s_off[17] ? 17'd0 : s_off[16:0];
        prod     = 25'(s_pos) * 25'(job_gain(job_reg));
        q_sum    = num_reg + (num_reg >> 15);
        q_back   = {1'b0, quo_reg, 15'd0} - 25'(quo_reg);
        rem      = num_reg - q_back;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD) begin
            // full-range jobs divide by 65534, so halve first
            num_reg <= job_wide(job_reg) ? (prod >> 1) : prod;
            quo_reg <= '0;
        end else if (state_reg == ST_DIV) begin
            if (step_reg == DIV_EST_STEP) begin
                quo_reg <= q_sum[23:15];
            end else if (rem >= 25'(AXIS_FULL)) begin
                quo_reg <= quo_reg + 9'd1;
            end
        end
        if (state_reg == ST_WB && job_reg == JOB_YAW) yaw_q_reg <= quo_reg;
    end

    // servo write back
    logic [9:0] pm, cl, cr;
    logic       r_pos, r_hi, r_lo;

    always_comb begin
        pm    = 10'd180 - 10'(quo_reg);
        cl    = 10'd180 - 10'(yaw_q_reg) + pm;
        cr    = 10'(yaw_q_reg) + pm;
        if (cl > 10'(ELEVON_CAP)) cl = 10'(ELEVON_CAP);
        if (cr > 10'(ELEVON_CAP)) cr = 10'(ELEVON_CAP);
        r_pos = roll > 0;
        r_hi  = roll >= 17'sd16383;
        r_lo  = roll <= -17'sd16383;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SERVO_SLOTS; i++) servo_reg[i] <= '0;
        end else if (state_reg == ST_WB) begin
            case (job_reg)
                JOB_ROLL_POS: if (r_pos) servo_reg[2] <= quo_reg[7:0];
                JOB_ROLL_HI:  if (r_hi) servo_reg[3] <= 8'd90 - quo_reg[7:0];
                JOB_ROLL_NEG: if (!r_pos) servo_reg[3] <= quo_reg[7:0];
                JOB_ROLL_LO:  if (r_lo) servo_reg[2] <= 8'd90 - quo_reg[7:0];
                JOB_PITCH: begin
                    servo_reg[4] <= cl[7:0];
                    servo_reg[5] <= cr[7:0];
                end
                JOB_THROTTLE: begin
                    servo_reg[0] <= quo_reg[7:0];
                    servo_reg[1] <= quo_reg[7:0];
                end
                JOB_PAN:  servo_reg[6] <= quo_reg[7:0];
                JOB_TILT: servo_reg[7] <= quo_reg[7:0];
                default: ;
            endcase
        end
    end

    // frame output
    logic [3:0] sidx, bofs;
    logic [1:0] grp;

    always_comb begin
        sidx = byte_reg - 4'd1;
        bofs = byte_reg - BYTE_BTN_FIRST;
        grp  = bofs[1:0];
        if (byte_reg == BYTE_PREFIX) begin
            m_tdata = prefix_reg;
        end else if (byte_reg <= BYTE_SERVO_END) begin
            m_tdata = servo_reg[sidx[2:0]];
        end else if (byte_reg <= BYTE_BTN_END) begin
            m_tdata = {btn_reg[{grp, 2'd0}], btn_reg[{grp, 2'd1}],
                       btn_reg[{grp, 2'd2}], btn_reg[{grp, 2'd3}]};
        end else begin
            m_tdata = csum_reg;
        end
        m_tlast = byte_reg == BYTE_CHECKSUM;
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            csum_reg <= '0;
        end else if (m_beat) begin
            csum_reg <= csum_reg ^ m_tdata;
        end
    end

    `SEFS_ASSERT_IMP(a_one_side, s_tready, !m_tvalid, "input taken while frame is out")
    `SEFS_ASSERT_NXT(a_frame_end, m_beat && m_tlast, s_tready, "no return to idle after frame")
    `SEFS_ASSERT_NXT(a_tick_frame, s_beat && s_tdata[1:0] == CMD_TICK,
                     m_tvalid && !m_tlast && m_tdata == prefix_reg, "tick did not open frame")

endmodule

// File: sim/stick_events_to_servo_frame_test.sv
// testbench for the stick event to servo frame block: directed and random events, ticks and register phases
module stick_events_to_servo_frame_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sefs_pkg::*;

    typedef struct {
        cmd_t            cmd;
        logic [7:0]      slot;
        logic [15:0]     val;
        bit              sync;
    } stick_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    stick_events_to_servo_frame uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    stick_item_t pending_items[$];
    frame_beat_t frame_beats_due[$];
    int          mismatches = 0;
    bit          burst = 1'b0;
    int          long_hold = 0;

    // shadow of the block
    logic [11:0] toggle_mask;
    logic [23:0] ms_counts;
    logic [14:0] deadzone;
    logic [7:0]  prefix;
    int          axis_pos[6];
    logic [1:0]  btn_level[12];
    int          throttle_mem;
    logic [7:0]  servo[8];

    function automatic longint lin_map(longint a1, longint a2, longint b1, longint b2,
                                       longint s);
        return b1 + ((s - a1) * (b2 - b1)) / (a2 - a1);
    endfunction

    function automatic void remix();
        longint r, yl, yr, pm, cl, cr, esc;
        r = axis_pos[AX_ROLL];
        if (r > 0) begin
            servo[2] = 8'(lin_map(0, AXIS_FULL, 0, 180, r));
            if (r >= AXIS_FULL / 2) servo[3] = 8'(lin_map(0, AXIS_FULL, 90, 0, r));
        end else begin
            servo[3] = 8'(lin_map(-AXIS_FULL, 0, 0, 180, r));
            if (r <= -(AXIS_FULL / 2)) servo[2] = 8'(lin_map(-AXIS_FULL, 0, 90, 0, r));
        end
        yl = lin_map(-AXIS_FULL, AXIS_FULL, 180, 0, axis_pos[AX_YAW]);
        yr = lin_map(-AXIS_FULL, AXIS_FULL, 0, 180, axis_pos[AX_YAW]);
        pm = lin_map(-AXIS_FULL, AXIS_FULL, 180, 0, axis_pos[AX_PITCH]);
        cl = yl + pm;
        cr = yr + pm;
        if (cl > ELEVON_CAP) cl = ELEVON_CAP;
        if (cr > ELEVON_CAP) cr = ELEVON_CAP;
        servo[4] = 8'(cl);
        servo[5] = 8'(cr);
        esc = lin_map(0, AXIS_FULL, 0, 254, axis_pos[AX_THROTTLE]);
        servo[0] = 8'(esc);
        servo[1] = 8'(esc);
        servo[6] = 8'(lin_map(-AXIS_FULL, AXIS_FULL, 0, 180, axis_pos[AX_PAN]));
        servo[7] = 8'(lin_map(-AXIS_FULL, AXIS_FULL, 0, 180, axis_pos[AX_TILT]));
    endfunction

    function automatic void predict_frame(cmd_t cmd, int n, int v);
        logic [1:0] cnt;
        int         mag, x;
        logic [7:0] bytes[13];
        logic [7:0] sum;
        case (cmd)
            CMD_BUTTON: begin
                if (n < BUTTON_SLOTS) begin
                    cnt = ms_counts[2*n +: 2];
                    if (toggle_mask[n]) begin
                        if (v == 1) btn_level[n] = (btn_level[n] == 0) ? 2'd1 : 2'd0;
                    end else if (cnt > 0) begin
                        if (v == 1) btn_level[n] = (btn_level[n] < cnt) ? btn_level[n] + 2'd1 : 2'd0;
                    end else begin
                        btn_level[n] = v[1:0];
                    end
                end
                remix();
            end
            CMD_AXIS: begin
                mag = v < 0 ? -v : v;
                x = (mag > int'(deadzone)) ? v : 0;
                if (n < 6) begin
                    if (n == AX_THROTTLE) begin
                        x = -x;
                        if (x > 0) begin
                            if (x > throttle_mem) begin
                                axis_pos[n] = x;
                                throttle_mem = x;
                            end
                        end else begin
                            x += AXIS_FULL;
                            if (x < throttle_mem) begin
                                axis_pos[n] = x;
                                throttle_mem = x;
                            end
                        end
                    end else begin
                        axis_pos[n] = x;
                    end
                end
                remix();
            end
            CMD_TICK: begin
                bytes[0] = prefix;
                for (int i = 0; i < 8; i++) bytes[1 + i] = servo[i];
                for (int i = 0; i < 3; i++)
                    bytes[9 + i] = {btn_level[4*i], btn_level[4*i+1], btn_level[4*i+2],
                                    btn_level[4*i+3]};
                sum = '0;
                for (int i = 0; i < 12; i++) sum ^= bytes[i];
                bytes[12] = sum;
                for (int i = 0; i < 13; i++)
                    frame_beats_due.push_back('{bytes[i], i == 12});
            end
            default: ;
        endcase
    endfunction

    // input acceptance and prediction
    bit in_done = 1'b0;
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            predict_frame(cmd_t'(s_tdata[1:0]), int'(s_tdata[9:2]),
                          int'($signed(s_tdata[25:10])));
            in_done = 1'b1;
        end
    end

    // driver
    int in_gap = 0;
    always @(negedge aclk) begin
        logic        v;
        stick_item_t it;
        v = s_tvalid;
        if (aresetn) begin
            if (in_done) begin
                in_done = 1'b0;
                v = 1'b0;
                in_gap = burst ? 0 : $urandom_range(0, 14);
            end
            if (!v) begin
                if (in_gap > 0) in_gap--;
                else if (pending_items.size() > 0 &&
                         !(pending_items[0].sync && frame_beats_due.size() > 0)) begin
                    it = pending_items.pop_front();
                    s_tdata <= {6'b0, it.val, it.slot, it.cmd};
                    v = 1'b1;
                end
            end
        end
        s_tvalid <= v;
    end

    // receiver stalls
    int out_stall = 0;
    bit out_done = 1'b0;
    always @(negedge aclk) begin
        if (long_hold > 0) long_hold <= long_hold - 1;
    end
    always @(negedge aclk) begin
        if (out_done) begin
            out_done = 1'b0;
            out_stall = burst ? 0 : $urandom_range(0, 14);
        end
        if (out_stall > 0) out_stall--;
        m_tready <= aresetn && long_hold == 0 && out_stall == 0;
    end

    // monitor
    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            out_done = 1'b1;
            if (frame_beats_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: data %02h last %b", m_tdata, m_tlast);
            end else begin
                want = frame_beats_due.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("beat mismatch: expected %02h/%b got %02h/%b",
                                 want.data, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [23:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TOGGLE_MASK: toggle_mask = value[11:0];
            CFG_MULTISTATE:  ms_counts   = value;
            CFG_DEADZONE:    deadzone    = value[14:0];
            default:         prefix      = value[7:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic [23:0] tm, logic [23:0] ms, logic [23:0] dz, logic [23:0] pf);
        write_reg(CFG_TOGGLE_MASK, tm);
        write_reg(CFG_MULTISTATE, ms);
        write_reg(CFG_DEADZONE, dz);
        write_reg(CFG_PREFIX, pf);
    endtask

    task automatic add(cmd_t c, int slot, int val, bit sync = 1'b0);
        pending_items.push_back('{c, 8'(slot), 16'(val), sync});
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_tvalid || frame_beats_due.size() > 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic add_random(int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 39) == 0) burst = ~burst;
            if (r < 25) add(CMD_TICK, $urandom_range(0, 255), $urandom, i % 60 == 59);
            else if (r < 55)
                add(CMD_BUTTON, $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                    : $urandom_range(0, 11),
                    $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 1));
            else if (r < 97)
                add(CMD_AXIS, $urandom_range(0, 5) == 0 ? $urandom_range(0, 255)
                    : $urandom_range(0, 5), $urandom);
            else add(CMD_NONE, $urandom_range(0, 255), $urandom);
        end
    endtask

    initial begin
        toggle_mask = 12'd2048;
        ms_counts = 24'd2;
        deadzone = 15'd5000;
        prefix = 8'hFF;
        throttle_mem = 0;
        foreach (axis_pos[i]) axis_pos[i] = 0;
        foreach (btn_level[i]) btn_level[i] = '0;
        foreach (servo[i]) servo[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, default registers
        add(CMD_TICK, 0, 0);
        add(CMD_BUTTON, 11, 1);
        add(CMD_BUTTON, 11, 0);
        add(CMD_BUTTON, 0, 1);
        add(CMD_BUTTON, 0, 1);
        add(CMD_BUTTON, 0, 1);
        add(CMD_BUTTON, 0, 2);
        add(CMD_BUTTON, 5, -1);
        add(CMD_BUTTON, 12, 1);
        add(CMD_BUTTON, 255, 1);
        add(CMD_AXIS, 0, 32767);
        add(CMD_TICK, 0, 0);
        add(CMD_AXIS, 0, -32768);
        add(CMD_AXIS, 1, 5000);
        add(CMD_AXIS, 3, -5001);
        add(CMD_AXIS, 2, -20000);
        add(CMD_AXIS, 2, -10000);
        add(CMD_AXIS, 2, 20000);
        add(CMD_AXIS, 2, 32767);
        add(CMD_AXIS, 4, 32767);
        add(CMD_AXIS, 5, -32768);
        add(CMD_AXIS, 6, 30000);
        add(CMD_NONE, 255, -1);
        add(CMD_TICK, 255, -1);
        drain();

        set_regs(24'h000, 24'h000000, 24'h0000, 24'h00);
        add_random(80);
        drain();

        set_regs(24'hFFF, 24'hFFFFFF, 24'h7FFF, 24'hFF);
        add_random(40);
        drain();

        set_regs(24'h000, 24'hFFFFFF, 24'd100, 24'h5A);
        add_random(100);
        // long receiver hold-off while ticks keep coming
        wait (pending_items.size() < 60);
        @(negedge aclk);
        long_hold <= 600;
        drain();

        set_regs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        add_random(110);
        drain();

        set_regs(24'($urandom), 24'($urandom), 24'($urandom_range(0, 8000)), 24'($urandom));
        add_random(100);
        drain();

        if (mismatches == 0 && frame_beats_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
